/* rtl/pesev_pkg.sv */
// pesev_pkg: shared types and codes for the prefix expression evaluator
// token actions, status codes, sequencer and arithmetic unit states
// no dependencies
package pesev_pkg;

    // token actions carried in the input tuser
    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_POW  = 3'd5;

    // result status codes carried in the output tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_DIVZERO   = 2'd3;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MULT,
        ALU_DIVIDE,
        ALU_SIGN
    } alu_state_t;

    // evaluator sequencer states
    typedef enum logic [3:0] {
        CTL_IDLE,
        CTL_TOKEN,
        CTL_RD_X,
        CTL_RD_Y,
        CTL_WAIT_ALU,
        CTL_POW_STEP,
        CTL_POW_MR,
        CTL_POW_MB,
        CTL_WRITE,
        CTL_FINISH
    } ctl_state_t;

endpackage

/* rtl/pesev_ram.sv */
// pesev_ram: generic single write port, single read port ram
// read data registered; no package dependencies
module pesev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pesev_alu.sv */
// pesev_alu: shared arithmetic unit of the evaluator
// registered add and subtract, bit-serial multiply, restoring signed divide
// depends on pesev_pkg
module pesev_alu #(
    parameter int WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pesev_pkg::alu_req_t req,
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    output pesev_pkg::alu_rsp_t rsp,
    output logic [WIDTH-1:0]    result
);

    localparam int CW = $clog2(WIDTH + 1);

    pesev_pkg::alu_state_t state_reg, state_next;
    logic [WIDTH-1:0]      acc_reg, acc_next;
    logic [WIDTH-1:0]      opa_reg, opa_next;
    logic [WIDTH-1:0]      opb_reg, opb_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [WIDTH-1:0]      res_reg, res_next;
    logic                  done_reg, done_next;

    logic [WIDTH-1:0] a_mag;
    logic [WIDTH-1:0] b_mag;
    logic [WIDTH-1:0] mul_sum;
    logic [WIDTH:0]   trial;

    assign a_mag   = a[WIDTH-1] ? (~a + WIDTH'(1)) : a;
    assign b_mag   = b[WIDTH-1] ? (~b + WIDTH'(1)) : b;
    assign mul_sum = acc_reg + (opb_reg[0] ? opa_reg : '0);
    assign trial   = {acc_reg, opa_reg[WIDTH-1]} - {1'b0, opb_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pesev_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // sequencing of one operation
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            pesev_pkg::ALU_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        pesev_pkg::ALU_ADD:
                        begin
                            res_next  = a + b;
                            done_next = 1'b1;
                        end
                        pesev_pkg::ALU_SUB:
                        begin
                            res_next  = a - b;
                            done_next = 1'b1;
                        end
                        pesev_pkg::ALU_MUL:
                        begin
                            acc_next = '0;
                            opa_next = a;
                            opb_next = b;
                            if (b == '0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = pesev_pkg::ALU_MULT;
                            end
                        end
                        pesev_pkg::ALU_DIV:
                        begin
                            acc_next   = '0;
                            opa_next   = a_mag;
                            opb_next   = b_mag;
                            neg_next   = a[WIDTH-1] ^ b[WIDTH-1];
                            cnt_next   = CW'(WIDTH);
                            state_next = pesev_pkg::ALU_DIVIDE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            // one multiplier bit per cycle, stops once no set bits remain
            pesev_pkg::ALU_MULT:
            begin
                acc_next = mul_sum;
                opa_next = {opa_reg[WIDTH-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[WIDTH-1:1]};
                if (opb_reg[WIDTH-1:1] == '0)
                begin
                    res_next   = mul_sum;
                    done_next  = 1'b1;
                    state_next = pesev_pkg::ALU_IDLE;
                end
            end
            // one quotient bit per cycle, quotient shifts into opa
            pesev_pkg::ALU_DIVIDE:
            begin
                if (!trial[WIDTH])
                begin
                    acc_next = trial[WIDTH-1:0];
                    opa_next = {opa_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[WIDTH-2:0], opa_reg[WIDTH-1]};
                    opa_next = {opa_reg[WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = pesev_pkg::ALU_SIGN;
                end
            end
            pesev_pkg::ALU_SIGN:
            begin
                res_next   = neg_reg ? (~opa_reg + WIDTH'(1)) : opa_reg;
                done_next  = 1'b1;
                state_next = pesev_pkg::ALU_IDLE;
            end
            default:
            begin
                state_next = pesev_pkg::ALU_IDLE;
            end
        endcase
    end

    assign rsp.busy = (state_reg != pesev_pkg::ALU_IDLE);
    assign rsp.done = done_reg;
    assign result   = res_reg;

    // a new operation only starts on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == pesev_pkg::ALU_IDLE)
        else $error("operation started while the unit was busy");

    // completion returns the unit to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == pesev_pkg::ALU_IDLE)
        else $error("completion flagged while the unit still works");

endmodule

/* rtl/prefix_expression_stack_evaluator.sv */
// prefix_expression_stack_evaluator: top level, token sequencer and operand stack
// depends on pesev_pkg, pesev_ram, pesev_alu
//
//  channel  dir  signals                        contents
//  s_axis   in   tvalid tready tdata tuser tlast tdata = operand_value, tuser = action,
//                                                tlast = is_last
//  m_axis   out  tvalid tready tdata tuser       tdata = result_value, tuser = status
//
// a push writes its operand to the stack; add, subtract, multiply and divide
// read the top two entries and run on the shared arithmetic unit; power runs
// square and multiply on the shared unit; the result replaces the two entries
// one token is in flight at a time
// reset clears stack count, error status and output valid; the stack ram needs no clear
// a last token waits in its final state while the previous result is still unread
module prefix_expression_stack_evaluator #(
    parameter int STACK_DEPTH = 32,
    parameter int DATA_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    pesev_pkg::ctl_state_t state_reg, state_next;
    logic [2:0]            action_reg, action_next;
    logic [DATA_WIDTH-1:0] opnd_reg, opnd_next;
    logic                  last_reg, last_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            err_reg, err_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] bottom_reg, bottom_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_data_reg, out_data_next;
    logic [1:0]            out_status_reg, out_status_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    pesev_pkg::alu_req_t   alu_req;
    pesev_pkg::alu_rsp_t   alu_rsp;
    logic [DATA_WIDTH-1:0] alu_a;
    logic [DATA_WIDTH-1:0] alu_b;
    logic [DATA_WIDTH-1:0] alu_result;

    logic [EW-1:0]         opnd_ext;
    logic [EW-1:0]         bottom_ext;
    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         cnt_m2;
    logic [1:0]            final_status;

    assign opnd_ext   = EW'($signed(s_axis_tdata));
    assign bottom_ext = EW'(bottom_reg);
    assign cnt_m1     = count_reg - CW'(1);
    assign cnt_m2     = count_reg - CW'(2);

    // status reported with the last token
    always_comb
    begin
        if (err_reg != pesev_pkg::ST_OK)
        begin
            final_status = err_reg;
        end
        else if (count_reg == CW'(1))
        begin
            final_status = pesev_pkg::ST_OK;
        end
        else
        begin
            final_status = pesev_pkg::ST_MALFORMED;
        end
    end

    // operand stack
    pesev_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared arithmetic unit
    pesev_alu #(
        .WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pesev_pkg::CTL_IDLE;
            count_reg     <= '0;
            err_reg       <= pesev_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        opnd_reg       <= opnd_next;
        last_reg       <= last_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        r_reg          <= r_next;
        b_reg          <= b_next;
        bottom_reg     <= bottom_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    // token sequencer
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        opnd_next       = opnd_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        r_next          = r_reg;
        b_next          = b_reg;
        bottom_next     = bottom_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = opnd_reg;
        ram_raddr       = cnt_m1[AW-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = pesev_pkg::ALU_ADD;
        alu_a           = x_reg;
        alu_b           = ram_rdata;
        case (state_reg)
            pesev_pkg::CTL_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next = s_axis_tuser;
                    opnd_next   = opnd_ext[DATA_WIDTH-1:0];
                    last_next   = s_axis_tlast;
                    state_next  = pesev_pkg::CTL_TOKEN;
                end
            end
            pesev_pkg::CTL_TOKEN:
            begin
                if (err_reg != pesev_pkg::ST_OK || action_reg > pesev_pkg::ACT_POW)
                begin
                    state_next = pesev_pkg::CTL_FINISH;
                end
                else if (action_reg == pesev_pkg::ACT_PUSH)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                    begin
                        err_next = pesev_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                        begin
                            bottom_next = opnd_reg;
                        end
                    end
                    state_next = pesev_pkg::CTL_FINISH;
                end
                else if (count_reg < CW'(2))
                begin
                    err_next   = pesev_pkg::ST_MALFORMED;
                    state_next = pesev_pkg::CTL_FINISH;
                end
                else
                begin
                    state_next = pesev_pkg::CTL_RD_X;
                end
            end
            // top of stack arrives, fetch the next one down
            pesev_pkg::CTL_RD_X:
            begin
                x_next     = ram_rdata;
                ram_raddr  = cnt_m2[AW-1:0];
                state_next = pesev_pkg::CTL_RD_Y;
            end
            pesev_pkg::CTL_RD_Y:
            begin
                y_next = ram_rdata;
                case (action_reg)
                    pesev_pkg::ACT_ADD:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = pesev_pkg::ALU_ADD;
                        state_next    = pesev_pkg::CTL_WAIT_ALU;
                    end
                    pesev_pkg::ACT_SUB:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = pesev_pkg::ALU_SUB;
                        state_next    = pesev_pkg::CTL_WAIT_ALU;
                    end
                    pesev_pkg::ACT_MUL:
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = pesev_pkg::ALU_MUL;
                        state_next    = pesev_pkg::CTL_WAIT_ALU;
                    end
                    pesev_pkg::ACT_DIV:
                    begin
                        if (ram_rdata == '0)
                        begin
                            err_next   = pesev_pkg::ST_DIVZERO;
                            state_next = pesev_pkg::CTL_FINISH;
                        end
                        else
                        begin
                            alu_req.start = 1'b1;
                            alu_req.op    = pesev_pkg::ALU_DIV;
                            state_next    = pesev_pkg::CTL_WAIT_ALU;
                        end
                    end
                    pesev_pkg::ACT_POW:
                    begin
                        // negative exponent: only bases of one and minus one survive
                        if (ram_rdata[DATA_WIDTH-1])
                        begin
                            if (x_reg == DATA_WIDTH'(1))
                            begin
                                r_next = DATA_WIDTH'(1);
                            end
                            else if (x_reg == '1)
                            begin
                                r_next = ram_rdata[0] ? '1 : DATA_WIDTH'(1);
                            end
                            else
                            begin
                                r_next = '0;
                            end
                            state_next = pesev_pkg::CTL_WRITE;
                        end
                        else
                        begin
                            r_next     = DATA_WIDTH'(1);
                            b_next     = x_reg;
                            state_next = pesev_pkg::CTL_POW_STEP;
                        end
                    end
                    default:
                    begin
                        state_next = pesev_pkg::CTL_FINISH;
                    end
                endcase
            end
            pesev_pkg::CTL_WAIT_ALU:
            begin
                if (alu_rsp.done)
                begin
                    r_next     = alu_result;
                    state_next = pesev_pkg::CTL_WRITE;
                end
            end
            // one exponent bit: multiply into the result if the bit is set, then square the base
            pesev_pkg::CTL_POW_STEP:
            begin
                if (y_reg[0])
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = pesev_pkg::ALU_MUL;
                    alu_a         = r_reg;
                    alu_b         = b_reg;
                    state_next    = pesev_pkg::CTL_POW_MR;
                end
                else if (y_reg[DATA_WIDTH-1:1] == '0)
                begin
                    state_next = pesev_pkg::CTL_WRITE;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = pesev_pkg::ALU_MUL;
                    alu_a         = b_reg;
                    alu_b         = b_reg;
                    state_next    = pesev_pkg::CTL_POW_MB;
                end
            end
            pesev_pkg::CTL_POW_MR:
            begin
                alu_a = b_reg;
                alu_b = b_reg;
                if (alu_rsp.done)
                begin
                    r_next = alu_result;
                    if (y_reg[DATA_WIDTH-1:1] == '0)
                    begin
                        state_next = pesev_pkg::CTL_WRITE;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_req.op    = pesev_pkg::ALU_MUL;
                        state_next    = pesev_pkg::CTL_POW_MB;
                    end
                end
            end
            pesev_pkg::CTL_POW_MB:
            begin
                if (alu_rsp.done)
                begin
                    b_next     = alu_result;
                    y_next     = {1'b0, y_reg[DATA_WIDTH-1:1]};
                    state_next = pesev_pkg::CTL_POW_STEP;
                end
            end
            // two popped, one pushed
            pesev_pkg::CTL_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_m2[AW-1:0];
                ram_wdata  = r_reg;
                count_next = cnt_m1;
                if (cnt_m2 == '0)
                begin
                    bottom_next = r_reg;
                end
                state_next = pesev_pkg::CTL_FINISH;
            end
            pesev_pkg::CTL_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = pesev_pkg::CTL_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = final_status;
                    out_data_next   = (final_status == pesev_pkg::ST_OK) ?
                                      bottom_ext[31:0] : 32'd0;
                    count_next      = '0;
                    err_next        = pesev_pkg::ST_OK;
                    state_next      = pesev_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = pesev_pkg::CTL_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == pesev_pkg::CTL_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // stack never holds more than its depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a failed expression reports a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != pesev_pkg::ST_OK) |-> m_axis_tdata == 32'd0)
        else $error("non-zero value with error status");

    // one token at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while a token is in work");

    // the first error sticks until the expression closes
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != pesev_pkg::ST_OK && state_reg != pesev_pkg::CTL_FINISH)
        |=> err_reg == $past(err_reg))
        else $error("error status changed before the last token");

endmodule
